### hdl/rrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants of the rounded rectangle border coverage block.
// ----------------------------------------------------------------------------
package rrb_pkg;

  // configuration register set
  typedef struct packed {
    logic [23:0] border_color;
    logic [6:0]  line_thickness;
    logic [11:0] corner_radius;
    logic [12:0] frame_height;
    logic [12:0] frame_width;
  } cfg_t;

  // register indexes (byte address 4*index)
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CORNER_RADIUS  = 3'd2;
  localparam logic [2:0] REG_LINE_THICKNESS = 3'd3;
  localparam logic [2:0] REG_BORDER_COLOR   = 3'd4;

  // reset values
  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd300;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd96;
  localparam logic [11:0] RST_CORNER_RADIUS  = 12'd8;
  localparam logic [6:0]  RST_LINE_THICKNESS = 7'd1;
  localparam logic [23:0] RST_BORDER_COLOR   = 24'd0;

endpackage

### hdl/rounded_rect_border_coverage.sv
`timescale 1ns / 1ps
// Pipeline: three front stages, one square root cell per root bit, two back
//   stages. Throughput: one pixel per cycle while out_tready is not held low.
// Reset: synchronous, active low; clears all stage valids and loads the
//   register defaults.
// ----------------------------------------------------------------------------
// rounded_rect_border_coverage
// Antialiased outline coverage of a rounded rectangle, premultiplied ARGB out.
// ----------------------------------------------------------------------------
module rounded_rect_border_coverage #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_x, pixel_y (from bit 0 up), zero padded to whole bytes
  input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_argb
  output logic [31:0] out_tdata,
  // covered
  output logic        out_tuser,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAG_BITS  = (COORD_BITS + 1 > 14) ? COORD_BITS + 1 : 14;
  localparam int DX_BITS   = MAG_BITS + 1;
  localparam int SQ_BITS   = 2 * DX_BITS + 1;
  localparam int RAD_RAW   = SQ_BITS + 2 * FRAC_BITS - 2;
  localparam int RAD_BITS  = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_BITS = RAD_BITS / 2;

  rrb_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  // register file
  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= rrb_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height   <= rrb_pkg::RST_FRAME_HEIGHT;
      cfg_r.corner_radius  <= rrb_pkg::RST_CORNER_RADIUS;
      cfg_r.line_thickness <= rrb_pkg::RST_LINE_THICKNESS;
      cfg_r.border_color   <= rrb_pkg::RST_BORDER_COLOR;
    end else if (wr_en) begin
      unique case (idx)
        rrb_pkg::REG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_pwdata[12:0];
        rrb_pkg::REG_FRAME_HEIGHT:   cfg_r.frame_height   <= cfg_pwdata[12:0];
        rrb_pkg::REG_CORNER_RADIUS:  cfg_r.corner_radius  <= cfg_pwdata[11:0];
        rrb_pkg::REG_LINE_THICKNESS: cfg_r.line_thickness <= cfg_pwdata[6:0];
        rrb_pkg::REG_BORDER_COLOR:   cfg_r.border_color   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      rrb_pkg::REG_FRAME_WIDTH:    cfg_prdata = 32'(cfg_r.frame_width);
      rrb_pkg::REG_FRAME_HEIGHT:   cfg_prdata = 32'(cfg_r.frame_height);
      rrb_pkg::REG_CORNER_RADIUS:  cfg_prdata = 32'(cfg_r.corner_radius);
      rrb_pkg::REG_LINE_THICKNESS: cfg_prdata = 32'(cfg_r.line_thickness);
      rrb_pkg::REG_BORDER_COLOR:   cfg_prdata = 32'(cfg_r.border_color);
      default:                     cfg_prdata = '0;
    endcase
  end

  // chain links: index 0 feeds the first cell
  logic                 c_valid [0:ROOT_BITS];
  logic                 c_ready [0:ROOT_BITS];
  logic [RAD_BITS-1:0]  c_rad   [0:ROOT_BITS];
  logic [ROOT_BITS+1:0] c_rem   [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] c_root  [0:ROOT_BITS];

  // edge excess, squares and radicand
  rrb_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAG_BITS   (MAG_BITS),
    .RAD_BITS   (RAD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .pixel_x (in_tdata[COORD_BITS-1:0]),
    .pixel_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .rad_o   (c_rad[0])
  );

  assign c_rem[0]  = '0;
  assign c_root[0] = '0;

  // square root, one cell per root bit
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    rrb_sqrt_cell #(
      .RAD_BITS  (RAD_BITS),
      .ROOT_BITS (ROOT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (c_valid[i]),
      .ready_o (c_ready[i]),
      .rad_i   (c_rad[i]),
      .rem_i   (c_rem[i]),
      .root_i  (c_root[i]),
      .valid_o (c_valid[i+1]),
      .ready_i (c_ready[i+1]),
      .rad_o   (c_rad[i+1]),
      .rem_o   (c_rem[i+1]),
      .root_o  (c_root[i+1])
    );
  end

  // coverage and shading, last stage is the output register
  rrb_back #(
    .FRAC_BITS (FRAC_BITS),
    .ROOT_BITS (ROOT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .valid_i    (c_valid[ROOT_BITS]),
    .ready_o    (c_ready[ROOT_BITS]),
    .rem_i      (c_rem[ROOT_BITS]),
    .root_i     (c_root[ROOT_BITS]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_argb (out_tdata),
    .covered    (out_tuser)
  );

endmodule

### hdl/rrb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_front
// Edge excess in half-pixel units, squares and radicand, three stages.
// ----------------------------------------------------------------------------
module rrb_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8,
  parameter int MAG_BITS   = 14,
  parameter int RAD_BITS   = 46
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrb_pkg::cfg_t         cfg,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [RAD_BITS-1:0]   rad_o
);

  localparam int SW      = MAG_BITS + 2;
  localparam int DX_BITS = MAG_BITS + 1;
  localparam int SQ_BITS = 2 * DX_BITS + 1;

  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;
  logic [DX_BITS-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic [2*DX_BITS-1:0] sqx_r, sqy_r;
  logic [RAD_BITS-1:0]  rad_r, rad_nxt;
  logic [SQ_BITS-1:0]   sum;

  logic signed [SW-1:0] w_s, h_s, t_s, r2_s;
  logic signed [SW-1:0] cx, cy, ax, ay, offx, offy, ex, ey;

  // stage handshake: a stage moves on when empty or when its successor moves
  assign rdy_c   = !vc_r || ready_i;
  assign rdy_b   = !vb_r || rdy_c;
  assign rdy_a   = !va_r || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vc_r;
  assign rad_o   = rad_r;

  // distance of the centre beyond the straight edges
  always_comb begin
    w_s  = $signed(SW'(cfg.frame_width));
    h_s  = $signed(SW'(cfg.frame_height));
    t_s  = $signed(SW'(cfg.line_thickness));
    r2_s = $signed(SW'({cfg.corner_radius, 1'b0}));
    cx   = $signed(SW'({pixel_x, 1'b1})) - w_s;
    cy   = $signed(SW'({pixel_y, 1'b1})) - h_s;
    ax   = (cx < 0) ? -cx : cx;
    ay   = (cy < 0) ? -cy : cy;
    offx = w_s - t_s - r2_s;
    offy = h_s - t_s - r2_s;
    ex   = ax - offx;
    ey   = ay - offy;
    dx_nxt = (ex > 0) ? ex[DX_BITS-1:0] : '0;
    dy_nxt = (ey > 0) ? ey[DX_BITS-1:0] : '0;
  end

  // squared length, scaled for the fraction bits of the root
  always_comb begin
    sum     = SQ_BITS'(sqx_r) + SQ_BITS'(sqy_r);
    rad_nxt = RAD_BITS'({sum, {(2 * FRAC_BITS - 2){1'b0}}});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= valid_i;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy_a && valid_i) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (rdy_b && va_r) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (rdy_c && vb_r) begin
      rad_r <= rad_nxt;
    end
  end

endmodule

### hdl/rrb_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_sqrt_cell
// One digit of the restoring square root: settles one root bit per cell.
// ----------------------------------------------------------------------------
module rrb_sqrt_cell #(
  parameter int RAD_BITS  = 46,
  parameter int ROOT_BITS = 23
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [RAD_BITS-1:0]  rad_i,
  input  logic [ROOT_BITS+1:0] rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [RAD_BITS-1:0]  rad_o,
  output logic [ROOT_BITS+1:0] rem_o,
  output logic [ROOT_BITS-1:0] root_o
);

  localparam int REM_BITS = ROOT_BITS + 2;

  logic                 v_r;
  logic [RAD_BITS-1:0]  rad_r, rad_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt, acc, trial;
  logic [ROOT_BITS-1:0] root_r, root_nxt;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    acc     = {rem_i[REM_BITS-3:0], rad_i[RAD_BITS-1 -: 2]};
    trial   = {root_i, 2'b01};
    rad_nxt = {rad_i[RAD_BITS-3:0], 2'b00};
    if (acc >= trial) begin
      rem_nxt  = acc - trial;
      root_nxt = {root_i[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_nxt  = acc;
      root_nxt = {root_i[ROOT_BITS-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

### hdl/rrb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_back
// Root rounding, coverage clamp and premultiplied colour, two stages.
// ----------------------------------------------------------------------------
module rrb_back #(
  parameter int FRAC_BITS = 8,
  parameter int ROOT_BITS = 23
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrb_pkg::cfg_t        cfg,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [ROOT_BITS+1:0] rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          pixel_argb,
  output logic                 covered
);

  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int LEN_BITS = ROOT_BITS + 1;
  localparam int DW = ((LEN_BITS > 12 + FRAC_BITS) ? LEN_BITS : 12 + FRAC_BITS) + 2;
  localparam int COV_BITS = FRAC_BITS + 1;
  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  logic vd_r, ve_r, rdy_d, rdy_e;
  logic [COV_BITS-1:0] cov_r, cov_nxt;
  logic                hit_r, hit_nxt;
  logic [31:0]         argb_r, argb_nxt;
  logic                cov_out_r;
  logic [LEN_BITS-1:0] len;
  logic                rnd;
  logic [7:0]          tp1;
  logic signed [DW-1:0] sdist, adist, half_w, cov;

  // (v * cov + half) >> FRAC_BITS
  function automatic logic [7:0] scale(input logic [7:0] v, input logic [COV_BITS-1:0] c);
    logic [COV_BITS+8:0] p;
    p = (COV_BITS + 9)'(v * c) + (COV_BITS + 9)'(1 << (FRAC_BITS - 1));
    return p[FRAC_BITS +: 8];
  endfunction

  assign rdy_e      = !ve_r || out_ready;
  assign rdy_d      = !vd_r || rdy_e;
  assign ready_o    = rdy_d;
  assign out_valid  = ve_r;
  assign pixel_argb = argb_r;
  assign covered    = cov_out_r;

  // rounded length, distance to the outline and clamped coverage
  always_comb begin
    rnd    = rem_i > REM_BITS'(root_i);
    len    = LEN_BITS'(root_i) + LEN_BITS'(rnd);
    sdist  = $signed(DW'(len)) - $signed(DW'({cfg.corner_radius, {FRAC_BITS{1'b0}}}));
    adist  = (sdist < 0) ? -sdist : sdist;
    tp1    = {1'b0, cfg.line_thickness} + 8'd1;
    half_w = $signed(DW'({tp1, {(FRAC_BITS - 1){1'b0}}}));
    cov    = half_w - adist;
    hit_nxt = cov > 0;
    cov_nxt = (cov > ONE) ? ONE[COV_BITS-1:0] : cov[COV_BITS-1:0];
  end

  // premultiplied output word
  always_comb begin
    if (hit_r) begin
      argb_nxt = {scale(8'hFF, cov_r),
                  scale(cfg.border_color[7:0], cov_r),
                  scale(cfg.border_color[15:8], cov_r),
                  scale(cfg.border_color[23:16], cov_r)};
    end else begin
      argb_nxt = '0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_d) vd_r <= valid_i;
      if (rdy_e) ve_r <= vd_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy_d && valid_i) begin
      cov_r <= cov_nxt;
      hit_r <= hit_nxt;
    end
    if (rdy_e && vd_r) begin
      argb_r    <= argb_nxt;
      cov_out_r <= hit_r;
    end
  end

endmodule

### hdl/rrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrb_checker
// Port-level checks on the result stream of the border coverage block.
// ----------------------------------------------------------------------------
module rrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // nothing offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // an uncovered pixel is all zero
  a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("uncovered pixel carries a value");

  // premultiplied: no channel exceeds alpha
  a_premult: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[23:16] <= out_tdata[31:24]) &&
                    (out_tdata[15:8] <= out_tdata[31:24]) &&
                    (out_tdata[7:0] <= out_tdata[31:24])))
    else $error("colour channel above alpha");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind rounded_rect_border_coverage rrb_checker u_rrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
